/* rtl/core/tlqs_pkg.sv */
// tlqs_pkg: shared widths, defaults and the job record for the two-level queue scheduler
// no dependencies; used by the interfaces, the job table and the top level
`timescale 1ns / 1ps

package tlqs_pkg;

    localparam int MAX_JOBS_DEF = 32;

    localparam int ID_W    = 16;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 22;

    // one stored job
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic               cls;
    } job_t;

endpackage

/* rtl/core/tlqs_stream_if.sv */
// tlqs_stream_if: valid/ready channels for job input and dispatch results
// depends on tlqs_pkg for field widths
`timescale 1ns / 1ps

interface tlqs_job_if;
    logic                        valid;
    logic                        ready;
    logic [tlqs_pkg::ID_W-1:0]    job_id;
    logic [tlqs_pkg::ARR_W-1:0]   arrival_time;
    logic [tlqs_pkg::BURST_W-1:0] burst_length;
    logic                        job_class;
    logic                        last_job;

    modport source (
        output valid, job_id, arrival_time, burst_length, job_class, last_job,
        input  ready
    );
    modport sink (
        input  valid, job_id, arrival_time, burst_length, job_class, last_job,
        output ready
    );
endinterface

interface tlqs_res_if;
    logic                       valid;
    logic                       ready;
    logic [tlqs_pkg::ID_W-1:0]   run_id;
    logic [tlqs_pkg::TIME_W-1:0] start_time;
    logic [tlqs_pkg::TIME_W-1:0] wait_time;
    logic [tlqs_pkg::TIME_W-1:0] finish_time;
    logic [tlqs_pkg::TIME_W-1:0] turnaround_time;
    logic                       last_result;

    modport source (
        output valid, run_id, start_time, wait_time, finish_time, turnaround_time,
               last_result,
        input  ready
    );
    modport sink (
        input  valid, run_id, start_time, wait_time, finish_time, turnaround_time,
               last_result,
        output ready
    );
endinterface

/* rtl/core/tlqs_job_mem.sv */
// tlqs_job_mem: job table, one write port and one registered read port
// depends on tlqs_pkg for the job record
`timescale 1ns / 1ps

module tlqs_job_mem #(
    parameter int DEPTH = tlqs_pkg::MAX_JOBS_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  tlqs_pkg::job_t       wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output tlqs_pkg::job_t       rd_data
);

    tlqs_pkg::job_t mem [DEPTH];
    tlqs_pkg::job_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/two_level_queue_scheduler.sv */
// two_level_queue_scheduler: non-preemptive two-level fcfs scheduler (system over user)
// depends on tlqs_pkg, tlqs_stream_if and tlqs_job_mem
//
//  channel  | dir | transfer moves                          | when
//  ---------+-----+-----------------------------------------+--------------------------
//  jobs     | in  | one job: id, arrival, burst, class, last | valid && ready
//  results  | out | one dispatch: id, start, wait, finish,   | valid && ready
//           |     | turnaround, last                         |
//
//  loading accepts one job per cycle; jobs is ready only while loading
//  each dispatch scans the n loaded jobs through the single table read port:
//  a read of each loaded job, a drain, a settle, then pick and turnaround;
//  the result is then held in S_OUT until results is ready
//  when nothing is ready the clock jumps to the next arrival, at the cost of
//  one more scan and pick
//  reset is asynchronous, active low; no clearing pass, the table needs none
//  a stalled results transfer holds the block, jobs stays low meanwhile
`timescale 1ns / 1ps

module two_level_queue_scheduler #(
    parameter int MAX_JOBS = tlqs_pkg::MAX_JOBS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    tlqs_job_if.sink          jobs,
    tlqs_res_if.source        results
);

    // index and count widths
    localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    // clock can reach about (MAX_JOBS + 1) * 2^16, never narrower than the result field
    localparam int CLK_NEED = $clog2((MAX_JOBS + 1) * 65536);
    localparam int CLK_W    = (CLK_NEED > tlqs_pkg::TIME_W) ? CLK_NEED : tlqs_pkg::TIME_W;
    // selection key: not-ready flag, class when ready, arrival
    localparam int KEY_W    = tlqs_pkg::ARR_W + 2;
    localparam int TW       = tlqs_pkg::TIME_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_PICK,
        S_TURN,
        S_OUT
    } state_t;

    state_t state_reg;

    // set bookkeeping
    logic [CNT_W-1:0]    loaded_reg;
    logic [CNT_W-1:0]    finished_reg;
    logic [CLK_W-1:0]    clock_reg;
    logic [MAX_JOBS-1:0] done_reg;

    // scan sequencer
    logic [CNT_W-1:0]    issue_reg;
    logic                rd_vld_reg;
    logic [IDX_W-1:0]    rd_pos_reg;

    // best candidate of the current scan
    logic                         best_found_reg;
    logic [KEY_W-1:0]             best_key_reg;
    logic [IDX_W-1:0]             best_pos_reg;
    logic [tlqs_pkg::ID_W-1:0]    best_id_reg;
    logic [tlqs_pkg::ARR_W-1:0]   best_arr_reg;
    logic [tlqs_pkg::BURST_W-1:0] best_burst_reg;

    // result register
    logic                      out_vld_reg;
    logic [tlqs_pkg::ID_W-1:0] out_id_reg;
    logic [TW-1:0]             out_start_reg;
    logic [TW-1:0]             out_wait_reg;
    logic [TW-1:0]             out_finish_reg;
    logic [TW-1:0]             out_turn_reg;
    logic                      out_last_reg;

    // table ports
    logic           wr_en;
    logic           rd_en;
    tlqs_pkg::job_t wr_job;
    tlqs_pkg::job_t rd_job;

    // candidate evaluation on the registered read data
    logic             cand_ready;
    logic [KEY_W-1:0] cand_key;
    logic             cand_take;
    logic [CLK_W-1:0] best_arr_ext;
    logic [CLK_W-1:0] best_burst_ext;
    logic             room;

    assign room = (loaded_reg < CNT_W'(MAX_JOBS));

    // table full: the job is dropped but its last flag still counts
    assign wr_en = (state_reg == S_LOAD) && jobs.valid && room;
    assign rd_en = (state_reg == S_SCAN) && (issue_reg < loaded_reg);

    assign wr_job.id      = jobs.job_id;
    assign wr_job.arrival = jobs.arrival_time;
    assign wr_job.burst   = jobs.burst_length;
    assign wr_job.cls     = jobs.job_class;

    tlqs_job_mem #(
        .DEPTH (MAX_JOBS),
        .IDX_W (IDX_W)
    ) u_job_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (loaded_reg[IDX_W-1:0]),
        .wr_data (wr_job),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_job)
    );

    // ready jobs sort ahead of waiting ones, system class ahead of user,
    // then by arrival; strict compare keeps the earlier-loaded job on ties
    assign cand_ready = ({{(CLK_W-tlqs_pkg::ARR_W){1'b0}}, rd_job.arrival} <= clock_reg);
    assign cand_key   = {~cand_ready, cand_ready & rd_job.cls, rd_job.arrival};
    assign cand_take  = rd_vld_reg && !done_reg[rd_pos_reg]
                        && (!best_found_reg || (cand_key < best_key_reg));

    assign best_arr_ext   = {{(CLK_W-tlqs_pkg::ARR_W){1'b0}}, best_arr_reg};
    assign best_burst_ext = {{(CLK_W-tlqs_pkg::BURST_W){1'b0}}, best_burst_reg};

    assign jobs.ready = (state_reg == S_LOAD);

    assign results.valid           = out_vld_reg;
    assign results.run_id          = out_id_reg;
    assign results.start_time      = out_start_reg;
    assign results.wait_time       = out_wait_reg;
    assign results.finish_time     = out_finish_reg;
    assign results.turnaround_time = out_turn_reg;
    assign results.last_result     = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            loaded_reg     <= '0;
            finished_reg   <= '0;
            clock_reg      <= '0;
            done_reg       <= '0;
            issue_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            rd_pos_reg     <= '0;
            best_found_reg <= 1'b0;
            best_key_reg   <= '0;
            best_pos_reg   <= '0;
            best_id_reg    <= '0;
            best_arr_reg   <= '0;
            best_burst_reg <= '0;
            out_vld_reg    <= 1'b0;
            out_id_reg     <= '0;
            out_start_reg  <= '0;
            out_wait_reg   <= '0;
            out_finish_reg <= '0;
            out_turn_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (jobs.valid)
                    begin
                        if (room)
                        begin
                            loaded_reg <= loaded_reg + 1'b1;
                        end
                        if (jobs.last_job)
                        begin
                            // set closed: start the schedule at tick zero
                            clock_reg      <= '0;
                            finished_reg   <= '0;
                            issue_reg      <= '0;
                            best_found_reg <= 1'b0;
                            state_reg      <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    if (issue_reg < loaded_reg)
                    begin
                        issue_reg  <= issue_reg + 1'b1;
                        rd_vld_reg <= 1'b1;
                        rd_pos_reg <= issue_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        rd_vld_reg <= 1'b0;
                        // last read evaluated, best candidate settled
                        if (!rd_vld_reg)
                        begin
                            state_reg <= S_PICK;
                        end
                    end
                end

                S_PICK:
                begin
                    if (!best_key_reg[KEY_W-1])
                    begin
                        // dispatch: start now, run the whole burst
                        out_id_reg    <= best_id_reg;
                        out_start_reg <= clock_reg[TW-1:0];
                        out_wait_reg  <= TW'(clock_reg - best_arr_ext);
                        clock_reg     <= clock_reg + best_burst_ext;
                        done_reg[best_pos_reg] <= 1'b1;
                        finished_reg  <= finished_reg + 1'b1;
                        state_reg     <= S_TURN;
                    end
                    else
                    begin
                        // idle gap: jump to the earliest pending arrival and rescan
                        clock_reg      <= best_arr_ext;
                        issue_reg      <= '0;
                        best_found_reg <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                end

                S_TURN:
                begin
                    out_finish_reg <= clock_reg[TW-1:0];
                    out_turn_reg   <= TW'(clock_reg - best_arr_ext);
                    out_last_reg   <= (finished_reg == loaded_reg);
                    out_vld_reg    <= 1'b1;
                    state_reg      <= S_OUT;
                end

                S_OUT:
                begin
                    if (results.ready)
                    begin
                        out_vld_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            // set complete: back to an empty table
                            loaded_reg   <= '0;
                            finished_reg <= '0;
                            clock_reg    <= '0;
                            done_reg     <= '0;
                            state_reg    <= S_LOAD;
                        end
                        else
                        begin
                            issue_reg      <= '0;
                            best_found_reg <= 1'b0;
                            state_reg      <= S_SCAN;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase

            // candidate compare, one table entry per cycle during a scan
            if (cand_take)
            begin
                best_found_reg <= 1'b1;
                best_key_reg   <= cand_key;
                best_pos_reg   <= rd_pos_reg;
                best_id_reg    <= rd_job.id;
                best_arr_reg   <= rd_job.arrival;
                best_burst_reg <= rd_job.burst;
            end
        end
    end

    // loading and dispatching never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(jobs.ready && results.valid))
        else $error("jobs ready while a result is pending");

    // dispatch count never runs past the loaded count
    a_finished_bound: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg <= loaded_reg)
        else $error("more dispatches than loaded jobs");

    // the final result empties the table
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.last_result)
        |=> (loaded_reg == '0) && (done_reg == '0) && jobs.ready)
        else $error("table not cleared after last result");

    // turnaround equals wait plus burst in modular result arithmetic
    a_time_relation: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.turnaround_time ==
            TW'(results.wait_time + results.finish_time - results.start_time)))
        else $error("result times inconsistent");

endmodule
